// File: hdl/trdt_pkg.sv
// ----------------------------------------------------------------------------
// trdt_pkg: shared types and constants of the triangle raster depth test
// Frame geometry, field widths, action codes and the transaction types that
// run between the front end, the back end and the divider.
// ----------------------------------------------------------------------------
package trdt_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 64;
  localparam int FRAME_HEIGHT = 64;
  localparam int PIXEL_COUNT  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(PIXEL_COUNT);
  localparam int COL_W        = $clog2(FRAME_WIDTH);
  localparam int ROW_W        = $clog2(FRAME_HEIGHT);

  // Field widths
  localparam int COORD_W  = 12;
  localparam int DEPTH_W  = 16;
  localparam int COLOR_W  = 32;
  localparam int COUNT_W  = 13;
  localparam int ACTION_W = 2;

  // Datapath widths: edge functions, depth numerators, quotients
  localparam int EDGE_W   = 28;
  localparam int ZDIFF_W  = 18;
  localparam int MUL_W    = EDGE_W + ZDIFF_W;
  localparam int NUM_W    = 48;
  localparam int QUO_W    = 17;
  localparam int DCNT_W   = $clog2(QUO_W + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] CLEAR_COUNT =
    (PIXEL_COUNT > 8191) ? COUNT_MAX : COUNT_W'(PIXEL_COUNT);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(PIXEL_COUNT - 1);
  localparam logic signed [DEPTH_W-1:0] DEPTH_RESET = {1'b1, {(DEPTH_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COL_LIMIT = COORD_W'(FRAME_WIDTH);
  localparam logic signed [COORD_W-1:0] ROW_LIMIT = COORD_W'(FRAME_HEIGHT);

  // Input actions
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DRAW  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

  // Classified commands handed to the back end
  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_DRAW,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  // Queue depths
  localparam int QCNT_W = 2;
  localparam logic [QCNT_W-1:0] QUEUE_DEPTH = 2'd2;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic [ADDR_W-1:0]           read_addr;
    logic signed [COORD_W-1:0]   ax;
    logic signed [COORD_W-1:0]   ay;
    logic signed [COORD_W-1:0]   bx;
    logic signed [COORD_W-1:0]   by;
    logic signed [COORD_W-1:0]   cx;
    logic signed [COORD_W-1:0]   cy;
    logic signed [DEPTH_W-1:0]   za;
    logic signed [DEPTH_W-1:0]   zb;
    logic signed [DEPTH_W-1:0]   zc;
    logic [COLOR_W-1:0]          color;
  } cmd_t;

  // Front to back: head of the command queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_t;

  // Back to front: dequeue strobe and reset sweep status
  typedef struct packed {
    logic take;
    logic init_busy;
  } back_ctl_t;

  typedef struct packed {
    logic [COLOR_W-1:0]        color;
    logic signed [DEPTH_W-1:0] depth;
    logic [COUNT_W-1:0]        count;
  } result_t;

  // Edge value is on the inside when zero or of the determinant's sign
  function automatic logic edge_agrees(input logic signed [EDGE_W-1:0] e,
                                       input logic signed [EDGE_W-1:0] det);
    edge_agrees = (e == '0) || (e[EDGE_W-1] == det[EDGE_W-1]);
  endfunction

endpackage

// File: hdl/triangle_raster_depth_test.sv
// ----------------------------------------------------------------------------
// triangle_raster_depth_test: triangle rasterizer with depth test
// Usage:
//   Input queue: present action and fields with push; a transaction is taken
//   when push is high and full is low. Clear fills the frame, draw rasters a
//   triangle with a strictly-greater depth test, read fetches one pixel.
//   Result queue: while empty is low the oldest result is on read_color,
//   read_depth and pixels_written; pop takes it. Exactly one result per item.
//   Configuration: cfg_write with cfg_data sets the clear depth (Q8.8); write
//   it only while the block is idle.
//   Execution: a draw walks the whole frame and runs the 17-step serial
//   divider once per covered pixel; one command executes at a time.
//   Two commands may wait at the input while one executes; two results may
//   wait at the output. When the receiver stalls, execution halts on the
//   finished command and full rises once the input queue fills.
//   Reset: the depth store is swept to the minimum depth, one entry per
//   cycle, with full held high meanwhile.
// ----------------------------------------------------------------------------
module triangle_raster_depth_test (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [trdt_pkg::ACTION_W-1:0]        action,
  input  logic signed [trdt_pkg::COORD_W-1:0]  vertex_a_x,
  input  logic signed [trdt_pkg::COORD_W-1:0]  vertex_a_y,
  input  logic signed [trdt_pkg::COORD_W-1:0]  vertex_b_x,
  input  logic signed [trdt_pkg::COORD_W-1:0]  vertex_b_y,
  input  logic signed [trdt_pkg::COORD_W-1:0]  vertex_c_x,
  input  logic signed [trdt_pkg::COORD_W-1:0]  vertex_c_y,
  input  logic signed [trdt_pkg::DEPTH_W-1:0]  depth_a,
  input  logic signed [trdt_pkg::DEPTH_W-1:0]  depth_b,
  input  logic signed [trdt_pkg::DEPTH_W-1:0]  depth_c,
  input  logic [trdt_pkg::COLOR_W-1:0]         color_value,
  input  logic                                 cfg_write,
  input  logic signed [trdt_pkg::DEPTH_W-1:0]  cfg_data,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [trdt_pkg::COLOR_W-1:0]         read_color,
  output logic signed [trdt_pkg::DEPTH_W-1:0]  read_depth,
  output logic [trdt_pkg::COUNT_W-1:0]         pixels_written
);

  trdt_pkg::cmdq_t     cmdq;
  trdt_pkg::back_ctl_t ctl;

  // Accept and classify
  trdt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .vertex_a_x  (vertex_a_x),
    .vertex_a_y  (vertex_a_y),
    .vertex_b_x  (vertex_b_x),
    .vertex_b_y  (vertex_b_y),
    .vertex_c_x  (vertex_c_x),
    .vertex_c_y  (vertex_c_y),
    .depth_a     (depth_a),
    .depth_b     (depth_b),
    .depth_c     (depth_c),
    .color_value (color_value),
    .ctl         (ctl),
    .cmdq        (cmdq)
  );

  // Execute
  trdt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .cmdq           (cmdq),
    .ctl            (ctl),
    .pop            (pop),
    .empty          (empty),
    .read_color     (read_color),
    .read_depth     (read_depth),
    .pixels_written (pixels_written)
  );

endmodule

// File: hdl/trdt_div.sv
// ----------------------------------------------------------------------------
// trdt_div: signed restoring divider for interpolated depth
// One quotient bit per cycle, truncating toward zero. The quotient of an
// inside pixel is a weighted mean of the vertex depths and fits QUO_W bits.
// ----------------------------------------------------------------------------
module trdt_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [trdt_pkg::NUM_W-1:0]     num,
  input  logic signed [trdt_pkg::EDGE_W-1:0]    den,
  output logic                                  busy,
  output logic signed [trdt_pkg::QUO_W-1:0]     quo
);

  logic [trdt_pkg::NUM_W-1:0]  num_mag;
  logic [trdt_pkg::EDGE_W-1:0] den_mag;
  logic [trdt_pkg::NUM_W-1:0]  rem;
  logic [trdt_pkg::NUM_W-1:0]  dsh;
  logic [trdt_pkg::QUO_W-1:0]  q;
  logic                        neg;
  logic [trdt_pkg::DCNT_W-1:0] cnt;
  logic                        ge;

  // Operand magnitudes
  assign num_mag = num[trdt_pkg::NUM_W-1] ? $unsigned(-num) : $unsigned(num);
  assign den_mag = den[trdt_pkg::EDGE_W-1] ? $unsigned(-den) : $unsigned(den);
  assign ge      = (rem >= dsh);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= trdt_pkg::DCNT_W'(trdt_pkg::QUO_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != trdt_pkg::DCNT_W'(1));
    end
  end

  // Shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num_mag;
      dsh <= trdt_pkg::NUM_W'(den_mag) << (trdt_pkg::QUO_W - 1);
      q   <= '0;
      neg <= num[trdt_pkg::NUM_W-1] ^ den[trdt_pkg::EDGE_W-1];
    end else if (busy) begin
      rem <= ge ? (rem - dsh) : rem;
      dsh <= dsh >> 1;
      q   <= {q[trdt_pkg::QUO_W-2:0], ge};
    end
  end

  assign quo = neg ? -$signed(q) : $signed(q);

endmodule

// File: hdl/trdt_front.sv
// ----------------------------------------------------------------------------
// trdt_front: input acceptance and command classification
// Decodes each input transaction, checks read coordinates against the frame
// and holds classified commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module trdt_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic [trdt_pkg::ACTION_W-1:0]          action,
  input  logic signed [trdt_pkg::COORD_W-1:0]    vertex_a_x,
  input  logic signed [trdt_pkg::COORD_W-1:0]    vertex_a_y,
  input  logic signed [trdt_pkg::COORD_W-1:0]    vertex_b_x,
  input  logic signed [trdt_pkg::COORD_W-1:0]    vertex_b_y,
  input  logic signed [trdt_pkg::COORD_W-1:0]    vertex_c_x,
  input  logic signed [trdt_pkg::COORD_W-1:0]    vertex_c_y,
  input  logic signed [trdt_pkg::DEPTH_W-1:0]    depth_a,
  input  logic signed [trdt_pkg::DEPTH_W-1:0]    depth_b,
  input  logic signed [trdt_pkg::DEPTH_W-1:0]    depth_c,
  input  logic [trdt_pkg::COLOR_W-1:0]           color_value,
  input  trdt_pkg::back_ctl_t                    ctl,
  output trdt_pkg::cmdq_t                        cmdq
);

  trdt_pkg::cmd_t              cmd_in;
  trdt_pkg::cmd_t              q_mem [2];
  logic                        wp;
  logic                        rp;
  logic [trdt_pkg::QCNT_W-1:0] cnt;
  logic                        in_frame;
  logic                        accept;
  logic                        take;

  // Read coordinates inside the frame
  assign in_frame = !vertex_a_x[trdt_pkg::COORD_W-1] && (vertex_a_x < trdt_pkg::COL_LIMIT) &&
                    !vertex_a_y[trdt_pkg::COORD_W-1] && (vertex_a_y < trdt_pkg::ROW_LIMIT);

  // Classify
  always_comb begin
    cmd_in.read_addr = trdt_pkg::ADDR_W'(vertex_a_y[trdt_pkg::ROW_W-1:0]) *
                       trdt_pkg::ADDR_W'(trdt_pkg::FRAME_WIDTH) +
                       trdt_pkg::ADDR_W'(vertex_a_x[trdt_pkg::COL_W-1:0]);
    cmd_in.ax    = vertex_a_x;
    cmd_in.ay    = vertex_a_y;
    cmd_in.bx    = vertex_b_x;
    cmd_in.by    = vertex_b_y;
    cmd_in.cx    = vertex_c_x;
    cmd_in.cy    = vertex_c_y;
    cmd_in.za    = depth_a;
    cmd_in.zb    = depth_b;
    cmd_in.zc    = depth_c;
    cmd_in.color = color_value;
    unique case (action)
      trdt_pkg::ACT_CLEAR: cmd_in.kind = trdt_pkg::CMD_CLEAR;
      trdt_pkg::ACT_DRAW:  cmd_in.kind = trdt_pkg::CMD_DRAW;
      trdt_pkg::ACT_READ:  cmd_in.kind = in_frame ? trdt_pkg::CMD_READ : trdt_pkg::CMD_NOP;
      trdt_pkg::ACT_NONE:  cmd_in.kind = trdt_pkg::CMD_NOP;
      default:             cmd_in.kind = trdt_pkg::CMD_NOP;
    endcase
  end

  assign full   = (cnt == trdt_pkg::QUEUE_DEPTH) || ctl.init_busy;
  assign accept = push && !full;
  assign take   = ctl.take && (cnt != '0);

  // Command queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (accept) wp <= wp + 1'b1;
      if (take)   rp <= rp + 1'b1;
      cnt <= cnt + trdt_pkg::QCNT_W'(accept) - trdt_pkg::QCNT_W'(take);
    end
  end

  // Command queue storage
  always_ff @(posedge clk) begin
    if (accept) q_mem[wp] <= cmd_in;
  end

  assign cmdq.valid = (cnt != '0);
  assign cmdq.cmd   = q_mem[rp];

endmodule

// File: hdl/trdt_back.sv
// ----------------------------------------------------------------------------
// trdt_back: command execution over the color and depth stores
// Sweeps the depth store for reset and both stores for clear, sets up incremental edge and depth
// numerators with one shared multiplier, walks the frame for a draw and
// queues results in a two-entry output queue.
// ----------------------------------------------------------------------------
module trdt_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic signed [trdt_pkg::DEPTH_W-1:0]   cfg_data,
  input  trdt_pkg::cmdq_t                       cmdq,
  output trdt_pkg::back_ctl_t                   ctl,
  input  logic                                  pop,
  output logic                                  empty,
  output logic [trdt_pkg::COLOR_W-1:0]          read_color,
  output logic signed [trdt_pkg::DEPTH_W-1:0]   read_depth,
  output logic [trdt_pkg::COUNT_W-1:0]          pixels_written
);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CLEAR = 4'd2;
  localparam logic [3:0] ST_SETUP = 4'd3;
  localparam logic [3:0] ST_TEST  = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_WRITE = 4'd6;
  localparam logic [3:0] ST_READ  = 4'd7;
  localparam logic [3:0] ST_READ2 = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;
  localparam logic [3:0] SETUP_LAST = 4'd13;

  logic [3:0]                          state;
  logic [3:0]                          step;
  logic [trdt_pkg::ADDR_W-1:0]         addr;
  logic [trdt_pkg::COL_W-1:0]          col;
  logic [trdt_pkg::ROW_W-1:0]          row;
  logic signed [trdt_pkg::DEPTH_W-1:0] clear_depth;
  trdt_pkg::cmd_t                      cmd;

  logic signed [trdt_pkg::EDGE_W-1:0]  du_i, du_j, dv_i, dv_j;
  logic signed [trdt_pkg::EDGE_W-1:0]  det, u_row, v_row, u_cur, v_cur, w_cur;
  logic signed [trdt_pkg::ZDIFF_W-1:0] dza, dzb;
  logic signed [trdt_pkg::NUM_W-1:0]   n_row, n_cur, dn_i, dn_j, prod;
  logic signed [trdt_pkg::EDGE_W-1:0]  mul_a;
  logic signed [trdt_pkg::ZDIFF_W-1:0] mul_b;
  logic signed [trdt_pkg::MUL_W-1:0]   mul_p;

  logic [trdt_pkg::COUNT_W-1:0]        count;
  logic [trdt_pkg::COLOR_W-1:0]        res_color;
  logic signed [trdt_pkg::DEPTH_W-1:0] res_depth;

  logic signed [trdt_pkg::DEPTH_W-1:0] depth_mem [trdt_pkg::PIXEL_COUNT];
  logic [trdt_pkg::COLOR_W-1:0]        color_mem [trdt_pkg::PIXEL_COUNT];
  logic signed [trdt_pkg::DEPTH_W-1:0] depth_rd;
  logic [trdt_pkg::COLOR_W-1:0]        color_rd;
  logic                                depth_we, color_we;
  logic signed [trdt_pkg::DEPTH_W-1:0] depth_wdata;

  logic                                in_tri, last_col, last_row, z_wins;
  logic                                div_busy;
  logic signed [trdt_pkg::QUO_W-1:0]   div_quo;

  trdt_pkg::result_t                   oq_mem [2];
  trdt_pkg::result_t                   oq_in;
  logic                                oq_wp, oq_rp, oq_push, oq_pop;
  logic [trdt_pkg::QCNT_W-1:0]         oq_cnt;

  // Pixel classification
  assign w_cur    = det - u_cur - v_cur;
  assign in_tri   = trdt_pkg::edge_agrees(u_cur, det) && trdt_pkg::edge_agrees(v_cur, det) &&
                    trdt_pkg::edge_agrees(w_cur, det);
  assign last_col = (col == trdt_pkg::COL_W'(trdt_pkg::FRAME_WIDTH - 1));
  assign last_row = (row == trdt_pkg::ROW_W'(trdt_pkg::FRAME_HEIGHT - 1));
  assign z_wins   = (div_quo > trdt_pkg::QUO_W'(depth_rd));

  assign ctl.take      = (state == ST_IDLE) && cmdq.valid;
  assign ctl.init_busy = (state == ST_INIT);

  // Depth divider
  trdt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_TEST && in_tri),
    .num   (n_cur),
    .den   (det),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // Shared setup multiplier operands
  always_comb begin
    unique case (step)
      4'd0:    begin mul_a = trdt_pkg::EDGE_W'(cmd.ax); mul_b = trdt_pkg::ZDIFF_W'(cmd.by); end
      4'd1:    begin mul_a = trdt_pkg::EDGE_W'(cmd.bx); mul_b = trdt_pkg::ZDIFF_W'(cmd.ay); end
      4'd2:    begin mul_a = trdt_pkg::EDGE_W'(cmd.bx); mul_b = trdt_pkg::ZDIFF_W'(cmd.cy); end
      4'd3:    begin mul_a = trdt_pkg::EDGE_W'(cmd.cx); mul_b = trdt_pkg::ZDIFF_W'(cmd.by); end
      4'd4:    begin mul_a = trdt_pkg::EDGE_W'(cmd.cx); mul_b = trdt_pkg::ZDIFF_W'(cmd.ay); end
      4'd5:    begin mul_a = trdt_pkg::EDGE_W'(cmd.ax); mul_b = trdt_pkg::ZDIFF_W'(cmd.cy); end
      4'd6:    begin mul_a = u_row; mul_b = dza; end
      4'd7:    begin mul_a = v_row; mul_b = dzb; end
      4'd8:    begin mul_a = det;   mul_b = trdt_pkg::ZDIFF_W'(cmd.zc); end
      4'd9:    begin mul_a = du_i;  mul_b = dza; end
      4'd10:   begin mul_a = dv_i;  mul_b = dzb; end
      4'd11:   begin mul_a = du_j;  mul_b = dza; end
      4'd12:   begin mul_a = dv_j;  mul_b = dzb; end
      default: begin mul_a = '0;    mul_b = '0;  end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Store write port
  always_comb begin
    depth_we    = 1'b0;
    color_we    = 1'b0;
    depth_wdata = trdt_pkg::DEPTH_RESET;
    unique case (state)
      ST_INIT: depth_we = 1'b1;
      ST_CLEAR: begin
        depth_we    = 1'b1;
        color_we    = 1'b1;
        depth_wdata = clear_depth;
      end
      ST_WRITE: begin
        depth_we    = z_wins;
        color_we    = z_wins;
        depth_wdata = div_quo[trdt_pkg::DEPTH_W-1:0];
      end
      default: ;
    endcase
  end

  // Stores
  always_ff @(posedge clk) begin
    if (depth_we) depth_mem[addr] <= depth_wdata;
    depth_rd <= depth_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (color_we) color_mem[addr] <= cmd.color;
    color_rd <= color_mem[addr];
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      addr        <= '0;
      clear_depth <= trdt_pkg::DEPTH_RESET;
    end else begin
      if (cfg_write) clear_depth <= cfg_data;
      unique case (state)
        ST_INIT: begin
          addr <= addr + 1'b1;
          if (addr == trdt_pkg::ADDR_LAST) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (cmdq.valid) begin
            addr <= '0;
            unique case (cmdq.cmd.kind)
              trdt_pkg::CMD_CLEAR: state <= ST_CLEAR;
              trdt_pkg::CMD_DRAW:  state <= ST_SETUP;
              trdt_pkg::CMD_READ: begin
                state <= ST_READ;
                addr  <= cmdq.cmd.read_addr;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == trdt_pkg::ADDR_LAST) state <= ST_DONE;
        end
        ST_SETUP: begin
          if (step == SETUP_LAST) state <= (det == '0) ? ST_DONE : ST_TEST;
        end
        ST_TEST: begin
          if (in_tri) begin
            state <= ST_DIV;
          end else begin
            addr <= addr + 1'b1;
            if (last_col && last_row) state <= ST_DONE;
          end
        end
        ST_DIV:   if (!div_busy) state <= ST_WRITE;
        ST_WRITE: begin
          addr  <= addr + 1'b1;
          state <= (last_col && last_row) ? ST_DONE : ST_TEST;
        end
        ST_READ:  state <= ST_READ2;
        ST_READ2: state <= ST_DONE;
        ST_DONE:  if (oq_cnt != trdt_pkg::QUEUE_DEPTH) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cmd       <= cmdq.cmd;
        step      <= '0;
        col       <= '0;
        row       <= '0;
        count     <= '0;
        res_color <= '0;
        res_depth <= '0;
        du_i      <= trdt_pkg::EDGE_W'(cmdq.cmd.by) - trdt_pkg::EDGE_W'(cmdq.cmd.cy);
        du_j      <= trdt_pkg::EDGE_W'(cmdq.cmd.cx) - trdt_pkg::EDGE_W'(cmdq.cmd.bx);
        dv_i      <= trdt_pkg::EDGE_W'(cmdq.cmd.cy) - trdt_pkg::EDGE_W'(cmdq.cmd.ay);
        dv_j      <= trdt_pkg::EDGE_W'(cmdq.cmd.ax) - trdt_pkg::EDGE_W'(cmdq.cmd.cx);
        dza       <= trdt_pkg::ZDIFF_W'(cmdq.cmd.za) - trdt_pkg::ZDIFF_W'(cmdq.cmd.zc);
        dzb       <= trdt_pkg::ZDIFF_W'(cmdq.cmd.zb) - trdt_pkg::ZDIFF_W'(cmdq.cmd.zc);
      end
      ST_CLEAR: count <= trdt_pkg::CLEAR_COUNT;
      ST_SETUP: begin
        // One product per step; each is folded in on the step after
        step <= step + 1'b1;
        prod <= trdt_pkg::NUM_W'(mul_p);
        unique case (step)
          4'd1:  det   <= trdt_pkg::EDGE_W'(prod);
          4'd2:  det   <= det - trdt_pkg::EDGE_W'(prod);
          4'd3:  u_row <= trdt_pkg::EDGE_W'(prod);
          4'd4:  u_row <= u_row - trdt_pkg::EDGE_W'(prod);
          4'd5:  v_row <= trdt_pkg::EDGE_W'(prod);
          4'd6: begin
            v_row <= v_row - trdt_pkg::EDGE_W'(prod);
            det   <= det + u_row;
          end
          4'd7: begin
            det   <= det + v_row;
            n_row <= prod;
          end
          4'd8:  n_row <= n_row + prod;
          4'd9:  n_row <= n_row + prod;
          4'd10: dn_i  <= prod;
          4'd11: dn_i  <= dn_i + prod;
          4'd12: dn_j  <= prod;
          4'd13: begin
            dn_j  <= dn_j + prod;
            u_cur <= u_row;
            v_cur <= v_row;
            n_cur <= n_row;
          end
          default: ;
        endcase
      end
      ST_TEST, ST_WRITE: begin
        if (state == ST_WRITE && z_wins && count != trdt_pkg::COUNT_MAX) begin
          count <= count + 1'b1;
        end
        // Step to the next pixel unless this one goes to the divider
        if (state == ST_WRITE || !in_tri) begin
          if (last_col) begin
            col   <= '0;
            row   <= row + 1'b1;
            u_row <= u_row + du_j;
            v_row <= v_row + dv_j;
            n_row <= n_row + dn_j;
            u_cur <= u_row + du_j;
            v_cur <= v_row + dv_j;
            n_cur <= n_row + dn_j;
          end else begin
            col   <= col + 1'b1;
            u_cur <= u_cur + du_i;
            v_cur <= v_cur + dv_i;
            n_cur <= n_cur + dn_i;
          end
        end
      end
      ST_READ2: begin
        res_color <= color_rd;
        res_depth <= depth_rd;
      end
      default: ;
    endcase
  end

  // Result queue
  assign oq_push     = (state == ST_DONE) && (oq_cnt != trdt_pkg::QUEUE_DEPTH);
  assign oq_pop      = pop && (oq_cnt != '0);
  assign oq_in.color = res_color;
  assign oq_in.depth = res_depth;
  assign oq_in.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp  <= 1'b0;
      oq_rp  <= 1'b0;
      oq_cnt <= '0;
    end else begin
      if (oq_push) oq_wp <= oq_wp + 1'b1;
      if (oq_pop)  oq_rp <= oq_rp + 1'b1;
      oq_cnt <= oq_cnt + trdt_pkg::QCNT_W'(oq_push) - trdt_pkg::QCNT_W'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq_mem[oq_wp] <= oq_in;
  end

  assign empty          = (oq_cnt == '0);
  assign read_color     = oq_mem[oq_rp].color;
  assign read_depth     = oq_mem[oq_rp].depth;
  assign pixels_written = oq_mem[oq_rp].count;

`ifndef NO_ASSERTIONS
  // An outside pixel moves straight on to the next address
  a_test_advance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST && !in_tri) |=> (addr == $past(addr) + 1'b1))
    else $error("raster walk skipped or repeated a pixel");

  // The depth compare only sees a finished quotient
  a_write_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> !div_busy)
    else $error("depth written before division finished");

  // A finished command waits while the result queue is full
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && oq_cnt == trdt_pkg::QUEUE_DEPTH) |=> (state == ST_DONE))
    else $error("result dropped on full queue");

  // No command is taken during the reset sweep
  a_init_no_take: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT) |-> !ctl.take)
    else $error("command taken during reset sweep");
`endif

endmodule

// File: sim/triangle_raster_depth_test_test.sv
// ----------------------------------------------------------------------------
// triangle_raster_depth_test_test: self-checking bench for the rasterizer
// Drives clear, draw, read and unused-action transactions through the input
// queue, predicts each result with an in-bench frame and depth buffer, and
// compares every popped result field by field. Both queue sides idle and
// stall at random, and the clear depth is changed between phases.
// ----------------------------------------------------------------------------
module triangle_raster_depth_test_test;

  localparam longint CYCLE_LIMIT = 60_000_000;

  typedef struct {
    logic [trdt_pkg::ACTION_W-1:0]        action;
    logic signed [trdt_pkg::COORD_W-1:0]  ax, ay, bx, by, cx, cy;
    logic signed [trdt_pkg::DEPTH_W-1:0]  za, zb, zc;
    logic [trdt_pkg::COLOR_W-1:0]         color;
  } raster_item_t;

  typedef struct {
    logic [trdt_pkg::COLOR_W-1:0]         color;
    logic signed [trdt_pkg::DEPTH_W-1:0]  depth;
    logic [trdt_pkg::COUNT_W-1:0]         count;
  } pixel_result_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  push = 1'b0;
  logic                                  full;
  logic [trdt_pkg::ACTION_W-1:0]         action = '0;
  logic signed [trdt_pkg::COORD_W-1:0]   vertex_a_x = '0, vertex_a_y = '0;
  logic signed [trdt_pkg::COORD_W-1:0]   vertex_b_x = '0, vertex_b_y = '0;
  logic signed [trdt_pkg::COORD_W-1:0]   vertex_c_x = '0, vertex_c_y = '0;
  logic signed [trdt_pkg::DEPTH_W-1:0]   depth_a = '0, depth_b = '0, depth_c = '0;
  logic [trdt_pkg::COLOR_W-1:0]          color_value = '0;
  logic                                  cfg_write = 1'b0;
  logic signed [trdt_pkg::DEPTH_W-1:0]   cfg_data = '0;
  logic                                  empty;
  logic                                  pop = 1'b0;
  logic [trdt_pkg::COLOR_W-1:0]          read_color;
  logic signed [trdt_pkg::DEPTH_W-1:0]   read_depth;
  logic [trdt_pkg::COUNT_W-1:0]          pixels_written;

  // Predicted frame state
  logic [trdt_pkg::COLOR_W-1:0]          frame_color [trdt_pkg::PIXEL_COUNT];
  int                                    frame_depth [trdt_pkg::PIXEL_COUNT];
  int                                    clear_level;
  pixel_result_t                         pending_results[$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  draws_sent = 0;
  int  pop_stall = 0;
  bit  no_gaps = 1'b0;
  longint cycle_count = 0;

  triangle_raster_depth_test u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .vertex_a_x(vertex_a_x), .vertex_a_y(vertex_a_y),
    .vertex_b_x(vertex_b_x), .vertex_b_y(vertex_b_y),
    .vertex_c_x(vertex_c_x), .vertex_c_y(vertex_c_y),
    .depth_a(depth_a), .depth_b(depth_b), .depth_c(depth_c),
    .color_value(color_value), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .empty(empty), .pop(pop), .read_color(read_color),
    .read_depth(read_depth), .pixels_written(pixels_written)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Edge sample lies inside when zero or of the determinant's sign
  function automatic bit on_inside(longint e, longint det);
    return (e == 0) || ((e > 0) == (det > 0));
  endfunction

  // Apply one transaction to the predicted frame and return its result
  function automatic pixel_result_t rasterize(raster_item_t it);
    pixel_result_t r;
    longint ax, ay, bx, by, cx, cy, det, u, v, w, z;
    int idx, cnt;
    r = '{default: '0};
    ax = it.ax; ay = it.ay; bx = it.bx; by = it.by; cx = it.cx; cy = it.cy;
    cnt = 0;
    case (it.action)
      trdt_pkg::ACT_CLEAR: begin
        for (int k = 0; k < trdt_pkg::PIXEL_COUNT; k++) begin
          frame_color[k] = it.color;
          frame_depth[k] = clear_level;
        end
        cnt = trdt_pkg::PIXEL_COUNT;
      end
      trdt_pkg::ACT_DRAW: begin
        det = ax * (by - cy) - bx * (ay - cy) + cx * (ay - by);
        if (det != 0) begin
          for (longint j = 0; j < trdt_pkg::FRAME_HEIGHT; j++) begin
            for (longint i = 0; i < trdt_pkg::FRAME_WIDTH; i++) begin
              u = i * (by - cy) - bx * (j - cy) + cx * (j - by);
              v = ax * (j - cy) - i * (ay - cy) + cx * (ay - j);
              w = det - u - v;
              if (on_inside(u, det) && on_inside(v, det) && on_inside(w, det)) begin
                z = (u * longint'(it.za) + v * longint'(it.zb) +
                     w * longint'(it.zc)) / det;
                idx = int'(j * trdt_pkg::FRAME_WIDTH + i);
                if (z > frame_depth[idx]) begin
                  frame_depth[idx] = int'(z);
                  frame_color[idx] = it.color;
                  cnt++;
                end
              end
            end
          end
        end
      end
      trdt_pkg::ACT_READ: begin
        if (ax >= 0 && ax < trdt_pkg::FRAME_WIDTH &&
            ay >= 0 && ay < trdt_pkg::FRAME_HEIGHT) begin
          idx = int'(ay * trdt_pkg::FRAME_WIDTH + ax);
          r.color = frame_color[idx];
          r.depth = trdt_pkg::DEPTH_W'(frame_depth[idx]);
        end
      end
      default: ;
    endcase
    r.count = (cnt > 8191) ? trdt_pkg::COUNT_W'(8191) : trdt_pkg::COUNT_W'(cnt);
    return r;
  endfunction

  // Random gap length: mostly short, a few long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Send one transaction; push stays high when no gap follows
  task automatic send_item(raster_item_t it);
    int gap;
    action <= it.action;
    vertex_a_x <= it.ax; vertex_a_y <= it.ay;
    vertex_b_x <= it.bx; vertex_b_y <= it.by;
    vertex_c_x <= it.cx; vertex_c_y <= it.cy;
    depth_a <= it.za; depth_b <= it.zb; depth_c <= it.zc;
    color_value <= it.color;
    push <= 1'b1;
    do @(posedge clk); while (full);
    pending_results.push_back(rasterize(it));
    items_sent++;
    if (it.action == trdt_pkg::ACT_DRAW) draws_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every expected result has been popped
  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_clear_depth(logic signed [trdt_pkg::DEPTH_W-1:0] value);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    clear_level = value;
    cfg_write <= 1'b0;
  endtask

  function automatic raster_item_t make_item(logic [trdt_pkg::ACTION_W-1:0] act);
    raster_item_t it;
    it.action = act;
    it.ax = trdt_pkg::COORD_W'($urandom); it.ay = trdt_pkg::COORD_W'($urandom);
    it.bx = trdt_pkg::COORD_W'($urandom); it.by = trdt_pkg::COORD_W'($urandom);
    it.cx = trdt_pkg::COORD_W'($urandom); it.cy = trdt_pkg::COORD_W'($urandom);
    it.za = trdt_pkg::DEPTH_W'($urandom); it.zb = trdt_pkg::DEPTH_W'($urandom);
    it.zc = trdt_pkg::DEPTH_W'($urandom);
    it.color = $urandom;
    return it;
  endfunction

  function automatic raster_item_t make_read(int col, int row);
    raster_item_t it;
    it = make_item(trdt_pkg::ACT_READ);
    it.ax = trdt_pkg::COORD_W'(col);
    it.ay = trdt_pkg::COORD_W'(row);
    return it;
  endfunction

  function automatic raster_item_t make_tri(int ax, int ay, int bx, int by,
                                            int cx, int cy, int za, int zb, int zc);
    raster_item_t it;
    it = make_item(trdt_pkg::ACT_DRAW);
    it.ax = trdt_pkg::COORD_W'(ax); it.ay = trdt_pkg::COORD_W'(ay);
    it.bx = trdt_pkg::COORD_W'(bx); it.by = trdt_pkg::COORD_W'(by);
    it.cx = trdt_pkg::COORD_W'(cx); it.cy = trdt_pkg::COORD_W'(cy);
    it.za = trdt_pkg::DEPTH_W'(za); it.zb = trdt_pkg::DEPTH_W'(zb);
    it.zc = trdt_pkg::DEPTH_W'(zc);
    return it;
  endfunction

  // Small triangle near or across the frame, random depths
  function automatic raster_item_t make_small_tri();
    raster_item_t it;
    int x0, y0;
    x0 = $urandom_range(0, 75) - 6;
    y0 = $urandom_range(0, 75) - 6;
    it = make_tri(x0, y0,
                  x0 + $urandom_range(0, 24) - 12, y0 + $urandom_range(0, 24) - 12,
                  x0 + $urandom_range(0, 24) - 12, y0 + $urandom_range(0, 24) - 12,
                  0, 0, 0);
    it.za = trdt_pkg::DEPTH_W'($urandom);
    it.zb = trdt_pkg::DEPTH_W'($urandom);
    it.zc = trdt_pkg::DEPTH_W'($urandom);
    return it;
  endfunction

  // Reset value of the clear depth, then a clear so every color is defined
  task automatic test_clear_and_read();
    send_item(make_item(trdt_pkg::ACT_CLEAR));
    send_item(make_read(0, 0));
    send_item(make_read(trdt_pkg::FRAME_WIDTH - 1, trdt_pkg::FRAME_HEIGHT - 1));
  endtask

  // Full-frame triangles of both windings, degenerate, depth ties
  task automatic test_triangles();
    send_item(make_tri(-100, -100, 300, -100, -100, 300, 32767, -32768, 0));
    send_item(make_read(5, 7));
    send_item(make_tri(-100, -100, -100, 300, 300, -100, 32767, 32767, 32767));
    send_item(make_read(63, 0));
    send_item(make_tri(-2048, -2048, 0, 0, 2047, 2047, 100, 200, 300));
    send_item(make_tri(10, 10, 10, 10, 40, 20, 0, 0, 0));
    send_item(make_tri(-5, -5, 8, -3, -2, 9, 32767, 32767, 32767));
    send_item(make_tri(-5, -5, 8, -3, -2, 9, 32767, 32767, 32767));
    send_item(make_read(0, 0));
  endtask

  // Reads outside the frame at every side and at the coordinate extremes
  task automatic test_reads_outside();
    send_item(make_read(-1, 0));
    send_item(make_read(trdt_pkg::FRAME_WIDTH, 0));
    send_item(make_read(0, trdt_pkg::FRAME_HEIGHT));
    send_item(make_read(2047, -2048));
    send_item(make_read(-2048, 2047));
  endtask

  task automatic test_unused_action();
    send_item(make_item(trdt_pkg::ACT_NONE));
    send_item(make_item(trdt_pkg::ACT_NONE));
  endtask

  // Clear depth extremes: a maximum clear blocks every draw
  task automatic test_clear_depth_extremes();
    write_clear_depth(16'sh7fff);
    send_item(make_item(trdt_pkg::ACT_CLEAR));
    send_item(make_tri(-100, -100, 300, -100, -100, 300, 32767, 32767, 32767));
    send_item(make_read(31, 31));
    write_clear_depth(16'sh8000);
    send_item(make_item(trdt_pkg::ACT_CLEAR));
    send_item(make_read(12, 40));
  endtask

  task automatic test_random(int n);
    raster_item_t it;
    int p;
    for (int k = 0; k < n; k++) begin
      if (k % 35 == 34) write_clear_depth(trdt_pkg::DEPTH_W'($urandom));
      if (k % 30 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      p = $urandom_range(0, 99);
      if (p < 8) it = make_item(trdt_pkg::ACT_CLEAR);
      else if (p < 45) it = make_small_tri();
      else if (p < 48) it = make_item(trdt_pkg::ACT_DRAW);
      else if (p < 50) begin
        it = make_small_tri();
        it.cx = it.ax; it.cy = it.ay;
      end else if (p < 88) it = make_read($urandom_range(0, 63), $urandom_range(0, 63));
      else if (p < 94) it = make_read($urandom, $urandom);
      else it = make_item(trdt_pkg::ACT_NONE);
      send_item(it);
    end
    no_gaps = 1'b0;
  endtask

  // Result pop pacing and checking
  always @(posedge clk) begin
    pixel_result_t exp_r;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: color %h depth %h count %0d",
               read_color, read_depth, pixels_written);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (read_color !== exp_r.color) begin
          $error("read_color: expected %h, got %h", exp_r.color, read_color);
          mismatches++;
        end
        if (read_depth !== exp_r.depth) begin
          $error("read_depth: expected %h, got %h", exp_r.depth, read_depth);
          mismatches++;
        end
        if (pixels_written !== exp_r.count) begin
          $error("pixels_written: expected %0d, got %0d", exp_r.count, pixels_written);
          mismatches++;
        end
      end
    end
    if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall <= pop_stall - 1;
    end else begin
      pop <= 1'b1;
      pop_stall <= no_gaps ? 0 : pick_gap();
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    clear_level = -32768;
    for (int k = 0; k < trdt_pkg::PIXEL_COUNT; k++) begin
      frame_color[k] = '0;
      frame_depth[k] = -32768;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_clear_depth(16'sh8000);
    test_clear_and_read();
    test_triangles();
    test_reads_outside();
    test_unused_action();
    test_clear_depth_extremes();
    write_clear_depth(16'sh0000);
    test_random(115);
    drain();
    repeat (50) @(posedge clk);
    $display("Covered %0d transactions (%0d draws), %0d results checked,",
             items_sent, draws_sent, results_seen);
    $display("with clear depth changes and random stalls on both queues.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
